>>> rtl/sfsu_pkg.sv
package sfsu_pkg;

  localparam int unsigned FrameBytes = 25;
  localparam int unsigned ChanCount  = 7;
  localparam int unsigned ChanWidth  = 11;
  localparam int unsigned DataBytes  = 10;
  localparam int unsigned OutWidth   = ((ChanCount * ChanWidth + 7) / 8) * 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] StartMark = 8'h0F;
  localparam logic [3:0] EndMark   = 4'h4;

  // Frame bytes 1 to 10 of a matched window, byte 1 at index 0.
  typedef logic [DataBytes-1:0][7:0] frame_data_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> rtl/sfsu_front.sv
module sfsu_front
  import sfsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output frame_data_t push_data_o
);

  logic [7:0] win_q [FrameBytes];
  logic [7:0] win_d [FrameBytes];
  logic       accept;
  logic       match;

  assign rx_ready_o = !q_stat_i.full;
  assign accept     = rx_valid_i && rx_ready_o;

  // Test the window as it stands after this byte is shifted in.
  assign match  = (win_q[1] == StartMark) && (rx_byte_i[3:0] == EndMark);
  assign push_o = accept && match;

  always_comb begin
    for (int i = 0; i < DataBytes; i++) begin
      push_data_o[i] = win_q[i + 2];
    end
  end

  always_comb begin
    for (int i = 0; i < FrameBytes - 1; i++) begin
      win_d[i] = win_q[i + 1];
    end
    win_d[FrameBytes - 1] = rx_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FrameBytes; i++) begin
        win_q[i] <= 8'h00;
      end
    end else if (accept) begin
      for (int i = 0; i < FrameBytes; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

>>> rtl/sfsu_queue.sv
module sfsu_queue
  import sfsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_data_t push_data_i,
  input  logic        pop_i,
  output frame_data_t pop_data_o,
  output queue_stat_t stat_o
);

  frame_data_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign stat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/sfsu_back.sv
module sfsu_back
  import sfsu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  queue_stat_t         q_stat_i,
  input  frame_data_t         q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutWidth-1:0] out_data_o
);

  logic                         out_valid_q, out_valid_d;
  logic [OutWidth-1:0]          out_data_q, out_data_d;
  logic [ChanCount*ChanWidth-1:0] chans;
  logic [7:0]                   b [DataBytes];

  always_comb begin
    for (int i = 0; i < DataBytes; i++) begin
      b[i] = q_data_i[i];
    end
  end

  // Little-endian 11-bit unpack of frame bytes 1 to 10 (b[0] is byte 1).
  assign chans[0*ChanWidth +: ChanWidth] = {b[1][2:0], b[0]};
  assign chans[1*ChanWidth +: ChanWidth] = {b[2][5:0], b[1][7:3]};
  assign chans[2*ChanWidth +: ChanWidth] = {b[4][0], b[3], b[2][7:6]};
  assign chans[3*ChanWidth +: ChanWidth] = {b[5][3:0], b[4][7:1]};
  assign chans[4*ChanWidth +: ChanWidth] = {b[6][6:0], b[5][7:4]};
  assign chans[5*ChanWidth +: ChanWidth] = {b[8][1:0], b[7], b[6][7]};
  assign chans[6*ChanWidth +: ChanWidth] = {b[9][4:0], b[8][7:2]};

  // Refill the output register whenever it is empty or being drained.
  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = OutWidth'(chans);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/sbus_frame_sync_channel_unpack_core.sv
// S.BUS frame finder: takes one received byte per transaction on the slave side and keeps
// the last 25 bytes in a shift window. When the oldest byte is 0x0F and the low nibble of
// the newest byte is 0x04, one transaction leaves on the master side carrying the first
// seven 11-bit channels. Input runs at one byte per clock; a match passes through the queue
// and then the output register on its way to the master side. A four-entry queue between
// the match stage and the output register absorbs master-side stalls; the slave side stalls
// only when that queue is full.
module sbus_frame_sync_channel_unpack_core
  import sfsu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [10:0] chan0, [21:11] chan1, [32:22] chan2, [43:33] chan3,
  // [54:44] chan4, [65:55] chan5, [76:66] chan6, [79:77] zero
  output logic [OutWidth-1:0] m_axis_tdata_o
);

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  frame_data_t push_data;
  frame_data_t pop_data;

  sfsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (s_axis_tvalid_i),
    .rx_ready_o (s_axis_tready_o),
    .rx_byte_i  (s_axis_tdata_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  sfsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (q_stat)
  );

  sfsu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

>>> rtl/sfsu_checker.sv
module sfsu_checker
  import sfsu_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [7:0]          s_axis_tdata_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutWidth-1:0] m_axis_tdata_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

  // Pad bits above the last channel stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OutWidth-1:ChanCount*ChanWidth] == '0))
    else $error("pad bits not zero");

  // A fresh result follows an accepted byte ending in the end mark, by way of the queue and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |->
      $past(s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i[3:0] == EndMark), 2))
    else $error("result without a matching end byte");

endmodule

bind sbus_frame_sync_channel_unpack_core sfsu_checker u_sfsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

>>> tb/sbus_frame_sync_channel_unpack_core_tb.sv
`timescale 1ns / 1ps

module sbus_frame_sync_channel_unpack_core_tb;
  import sfsu_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 240;
  localparam int unsigned PhaseFrames = 8;
  localparam int unsigned DrainCycles = 12;

  typedef logic [ChanCount-1:0][ChanWidth-1:0] chan_set_t;

  class frame_scoreboard;
    logic [7:0] window [FrameBytes];
    chan_set_t  expected_frames [$];
    int         errors;
    int         bytes_seen;
    int         frames_found;
    int         frames_checked;

    function new();
      foreach (window[i]) window[i] = 8'h00;
      errors = 0;
      bytes_seen = 0;
      frames_found = 0;
      frames_checked = 0;
    endfunction

    // Channels of the current window, bytes 1 to 10 packed little-endian.
    function chan_set_t decode_window();
      chan_set_t c;
      c[0] = {window[2][2:0], window[1]};
      c[1] = {window[3][5:0], window[2][7:3]};
      c[2] = {window[5][0], window[4], window[3][7:6]};
      c[3] = {window[6][3:0], window[5][7:1]};
      c[4] = {window[7][6:0], window[6][7:4]};
      c[5] = {window[9][1:0], window[8], window[7][7]};
      c[6] = {window[10][4:0], window[9][7:2]};
      return c;
    endfunction

    function void push_rx_byte(logic [7:0] rx);
      for (int i = 0; i < FrameBytes - 1; i++) window[i] = window[i+1];
      window[FrameBytes-1] = rx;
      bytes_seen++;
      if (window[0] == StartMark && window[FrameBytes-1][3:0] == EndMark) begin
        expected_frames.push_back(decode_window());
        frames_found++;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_frame(logic [OutWidth-1:0] data);
      chan_set_t exp_set;
      logic [ChanWidth-1:0] got;
      if (expected_frames.size() == 0) begin
        report($sformatf("unexpected frame transaction, tdata=%h", data));
      end else begin
        exp_set = expected_frames.pop_front();
        frames_checked++;
        for (int k = 0; k < ChanCount; k++) begin
          got = data[k*ChanWidth +: ChanWidth];
          if (got !== exp_set[k]) begin
            report($sformatf("frame %0d chan%0d got %0d expected %0d",
                             frames_checked, k, got, exp_set[k]));
          end
        end
      end
    endtask

    task check_drained();
      if (expected_frames.size() != 0) begin
        report($sformatf("%0d frames never appeared", expected_frames.size()));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [7:0]          s_data = 8'h00;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutWidth-1:0] m_axis_tdata_o;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned cycle_count = 0;
  frame_scoreboard sb;

  sbus_frame_sync_channel_unpack_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_ready <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) sb.push_rx_byte(s_data);
      if (m_axis_tvalid_o && m_ready) sb.check_frame(m_axis_tdata_o);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL sbus_frame_sync_channel_unpack_core");
    $finish;
  end

  // Hold valid across back-to-back bytes; drop it only for idle cycles.
  task send_byte(logic [7:0] rx);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= rx;
    do @(posedge clk_i); while (!(s_valid && s_axis_tready_o));
  endtask

  task send_frame(int unsigned len);
    logic [7:0] payload_fill;
    int unsigned style;
    bit overlap;
    style = $urandom_range(9);
    payload_fill = (style == 0) ? 8'h00 : 8'hFF;
    overlap = ($urandom_range(7) == 0);
    send_byte(StartMark);
    for (int i = 1; i < len && i < FrameBytes - 1; i++) begin
      if (i == 1 && overlap) send_byte(StartMark);
      else if (i <= DataBytes && style <= 1) send_byte(payload_fill);
      else send_byte(8'($urandom_range(255)));
    end
    if (len >= FrameBytes) begin
      send_byte({4'($urandom_range(15)), EndMark});
      if (overlap) send_byte({4'($urandom_range(15)), EndMark});
    end
  endtask

  task run_phase(int unsigned s_idle, int unsigned r_idle);
    int unsigned first_byte;
    int unsigned first_frame;
    int unsigned pick;
    send_idle = s_idle;
    recv_idle = r_idle;
    first_byte = sb.bytes_seen;
    first_frame = sb.frames_found;
    while (sb.bytes_seen - first_byte < PhaseBytes ||
           sb.frames_found - first_frame < PhaseFrames) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        send_frame(FrameBytes);
      end else if (pick < 9) begin
        // broken frame: start mark followed by a short run
        send_frame($urandom_range(FrameBytes - 2, 2));
      end else begin
        repeat ($urandom_range(5, 1)) begin
          case ($urandom_range(3))
            0: send_byte(StartMark);
            1: send_byte({4'($urandom_range(15)), EndMark});
            default: send_byte(8'($urandom_range(255)));
          endcase
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two overlapping frames; end marks appear early while the window is still
    // filling from reset.
    send_byte(StartMark);
    send_byte(StartMark);
    repeat (10) send_byte(8'hFF);
    send_byte(8'h04);
    send_byte(8'h14);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h04);
    send_byte(8'hF0);
    send_byte(8'h0F);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'hFE);
    send_byte(8'h04);
    send_byte(8'hF4);

    run_phase(17, 59);
    run_phase(59, 17);
    run_phase(0, 0);

    s_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.check_drained();

    $display("covered %0d received bytes and %0d decoded frames,", sb.bytes_seen,
             sb.frames_checked);
    $display("including overlaps and broken frames, under three stall profiles");
    if (sb.errors == 0) begin
      $display("PASS sbus_frame_sync_channel_unpack_core");
    end else begin
      $display("FAIL sbus_frame_sync_channel_unpack_core");
    end
    $finish;
  end

endmodule
